[sv/aff_pkg.sv]
// Shared types and constants for the ACL frame filter.
package aff_pkg;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  IHL_MASK   = 4'hF;
    localparam int          ETH_HDR    = 14;
    localparam int          IPV4_HDR   = 20;
    localparam int          IPV6_HDR   = 40;
    localparam int          CAP_BYTES  = 58;
    localparam logic [6:0]  COUNT_MAX  = 7'd127;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_RULE  = 1'b1;

    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_DEFAULT = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;

    localparam logic [1:0] RSN_OFF     = 2'd0;
    localparam logic [1:0] RSN_SHORT   = 2'd1;
    localparam logic [1:0] RSN_HIT     = 2'd2;
    localparam logic [1:0] RSN_DEFAULT = 2'd3;

    localparam logic [1:0] DIR_ANY     = 2'd0;
    localparam logic [1:0] DIR_EGRESS  = 2'd1;
    localparam logic [1:0] DIR_INGRESS = 2'd2;

    typedef struct packed {
        logic cap;
        logic cap_last;
        logic rwr;
        logic classify;
        logic rd;
        logic eval;
        logic next_word;
        logic next_rule;
        logic fin_hit;
        logic fin_def;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic need_walk;
        logic fail;
        logic word_last;
        logic rules_done;
        logic out_free;
    } t_stat;

endpackage

[sv/acl_frame_filter.sv]
// Top level of the first-match five-tuple ACL frame filter.
// Use: frame bytes and rule-word writes enter on the s_axis request channel
//   (tuser = 0 frame byte, 1 rule word write; tlast marks the last byte).
//   One verdict per frame leaves on m_axis after the last byte.
// Registers on the APB port: 0x0 filter_enable, 0x4 default_allow,
//   0x8 rule_count.
// Sequence: a frame byte or rule write is accepted while the block is idle.
//   After the last byte the frame is classified; then, if a walk is needed,
//   the words of each rule are read from the rule RAM and compared in turn,
//   up to eight words per rule, until a rule matches or the list ends, and
//   the verdict is loaded into the output register once it is free.
// Throughput: input is held off from the last byte until the verdict is
//   loaded into the output register; the single read port of the rule RAM sets the
//   walk length.
// Reset: clears the byte counter, direction, state and output valid; rule
//   words are undefined until written.
// Stall: a verdict waits in the output register while m_axis_tready is low;
//   a second verdict waits in the block until the register frees.
module acl_frame_filter #(
    parameter int RULES        = 16,
    parameter int HEADER_BYTES = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] frame_byte, [8] direction, [12:9] rule_index,
    // [15:13] rule_word_select, [79:16] rule_word
    input  logic [79:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // [0] operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] allow, [2:1] verdict_reason, [6:3] matched_rule, [7] zero
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aff_pkg::*;

    logic       r_enable, r_default;
    logic [4:0] r_count;
    t_cmd       cmd;
    t_stat      stat;
    logic [6:0] out_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_default <= 1'b1;
            r_count   <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ENABLE:  r_enable  <= pwdata[0];
                REG_DEFAULT: r_default <= pwdata[0];
                REG_COUNT:   r_count   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE:  prdata = {31'd0, r_enable};
            REG_DEFAULT: prdata = {31'd0, r_default};
            REG_COUNT:   prdata = {27'd0, r_count};
            default:     prdata = '0;
        endcase
    end

    aff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .i_op    (s_axis_tuser),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    aff_dp #(.RULES(RULES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_byte      (s_axis_tdata[7:0]),
        .i_dir       (s_axis_tdata[8]),
        .i_ridx      (s_axis_tdata[12:9]),
        .i_rsel      (s_axis_tdata[15:13]),
        .i_rword     (s_axis_tdata[79:16]),
        .i_enable    (r_enable),
        .i_default   (r_default),
        .i_count     (r_count),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};
endmodule

[sv/aff_ram.sv]
// Generic single-write, registered-read RAM.
module aff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[sv/aff_ctrl.sv]
// Sequencer for frame capture, classification and the rule walk.
module aff_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    input  logic          i_op,
    input  aff_pkg::t_stat i_stat,
    output logic          o_ready,
    output aff_pkg::t_cmd o_cmd
);
    import aff_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CLASS, S_READ, S_EVAL, S_OUT} t_state;
    t_state r_state, n_state;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_op == OP_RULE) begin
                    o_cmd.rwr = 1'b1;
                end else if (acc) begin
                    o_cmd.cap      = 1'b1;
                    o_cmd.cap_last = i_last;
                    if (i_last) n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = i_stat.need_walk ? S_READ : S_OUT;
            end
            S_READ: begin
                if (i_stat.rules_done) begin
                    o_cmd.fin_def = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.fail) begin
                    o_cmd.next_rule = 1'b1;
                    n_state = S_READ;
                end else if (i_stat.word_last) begin
                    o_cmd.fin_hit = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.next_word = 1'b1;
                    n_state = S_READ;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[sv/aff_dp.sv]
// Header capture, rule store, rule compare and result register.
module aff_dp #(
    parameter int RULES        = 16,
    parameter int HEADER_BYTES = 80
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aff_pkg::t_cmd i_cmd,
    output aff_pkg::t_stat o_stat,
    input  logic [7:0]    i_byte,
    input  logic          i_dir,
    input  logic [3:0]    i_ridx,
    input  logic [2:0]    i_rsel,
    input  logic [63:0]   i_rword,
    input  logic          i_enable,
    input  logic          i_default,
    input  logic [4:0]    i_count,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [6:0]    o_out_data
);
    import aff_pkg::*;

    localparam int AW = $clog2(RULES * 8);
    localparam int CW = $clog2(RULES + 1);

    logic [7:0]    r_hdr [CAP_BYTES];
    logic [6:0]    r_cnt, r_len, cnt_inc;
    logic          r_dir;
    logic [3:0]    r_ihl;
    logic [31:0]   r_v4p;
    logic [7:0]    v4_off;

    logic          r_fam, r_ports;
    logic [7:0]    r_proto;
    logic [15:0]   r_sport, r_dport;
    logic [63:0]   r_shi, r_slo, r_dhi, r_dlo;
    logic [63:0]   r_flags;
    logic [CW-1:0] r_rule;
    logic [2:0]    r_word;
    logic [6:0]    r_res;
    logic          r_ov;
    logic [6:0]    r_od;

    logic [63:0]   rdata, flags;
    logic          ram_we;
    logic [CW-1:0] ncap;

    logic [15:0]   etype;
    logic [7:0]    ihl4;
    logic          v4_ok, v6_ok, is_v4, is_v6;
    logic [7:0]    proto_c;
    logic          ports_c;
    logic [63:0]   smac, dmac;
    logic [1:0]    want;
    logic          fail;

    function automatic logic [7:0] clamp_len(input logic [7:0] p, input logic fam);
        logic [7:0] q;
        q = p;
        if (!fam && q > 8'd32) q = 8'd32;
        if (q > 8'd128) q = 8'd128;
        return q;
    endfunction

    function automatic logic [63:0] mask_hi(input logic [7:0] p);
        logic [63:0] m;
        if (p >= 8'd64) m = '1;
        else            m = ~({64{1'b1}} >> p[5:0]);
        return m;
    endfunction

    function automatic logic [63:0] mask_lo(input logic [7:0] p);
        logic [63:0] m;
        logic [7:0]  q;
        q = p - 8'd64;
        if (p <= 8'd64)       m = '0;
        else if (p >= 8'd128) m = '1;
        else                  m = ~({64{1'b1}} >> q[5:0]);
        return m;
    endfunction

    assign ram_we = i_cmd.rwr && (32'(i_ridx) < RULES);

    aff_ram #(.WIDTH(64), .DEPTH(RULES * 8)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'({i_ridx, i_rsel})),
        .i_wdata (i_rword),
        .i_re    (i_cmd.rd),
        .i_raddr (AW'({r_rule, r_word})),
        .o_rdata (rdata)
    );

    assign cnt_inc = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 7'd1;
    assign v4_off  = 8'(r_cnt) - 8'(ETH_HDR) - {2'b00, r_ihl, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_dir <= 1'b0;
        end else if (i_cmd.cap) begin
            if (r_cnt == '0) r_dir <= i_dir;
            r_cnt <= i_cmd.cap_last ? 7'd0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            if (32'(r_cnt) < CAP_BYTES) r_hdr[6'(r_cnt)] <= i_byte;
            if (32'(r_cnt) == ETH_HDR) r_ihl <= i_byte[3:0] & IHL_MASK;
            if (v4_off < 8'd4 && 32'(r_cnt) < HEADER_BYTES)
                r_v4p[8 * (3 - 32'(v4_off[1:0])) +: 8] <= i_byte;
            if (i_cmd.cap_last) r_len <= cnt_inc;
        end
    end

    assign etype = {r_hdr[12], r_hdr[13]};
    assign ihl4  = {2'b00, r_ihl, 2'b00};
    assign v4_ok = (r_len >= 7'(ETH_HDR + IPV4_HDR)) && (ihl4 >= 8'(IPV4_HDR))
                   && (8'(r_len) >= ihl4 + 8'(ETH_HDR));
    assign v6_ok = (r_len >= 7'(ETH_HDR + IPV6_HDR));
    assign is_v4 = (etype == ETYPE_IPV4);
    assign is_v6 = (etype == ETYPE_IPV6);
    assign proto_c = is_v4 ? r_hdr[23] : r_hdr[20];
    always_comb begin
        if (is_v4) begin
            ports_c = (proto_c == PROTO_TCP || proto_c == PROTO_UDP)
                      && (8'(r_len) >= ihl4 + 8'(ETH_HDR + 4))
                      && (32'(ihl4) + ETH_HDR + 4 <= HEADER_BYTES);
        end else begin
            ports_c = (proto_c == PROTO_TCP || proto_c == PROTO_UDP)
                      && (r_len >= 7'(CAP_BYTES)) && (CAP_BYTES <= HEADER_BYTES);
        end
    end

    assign smac = {16'h0, r_hdr[6], r_hdr[7], r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11]};
    assign dmac = {16'h0, r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3], r_hdr[4], r_hdr[5]};
    assign want = r_dir ? DIR_EGRESS : DIR_INGRESS;
    assign ncap = (32'(i_count) > RULES) ? CW'(RULES) : CW'(i_count);
    assign flags = (r_word == 3'd0) ? rdata : r_flags;

    always_comb begin
        case (r_word)
            3'd0: fail = (flags[2:1] != DIR_ANY && flags[2:1] != want)
                         || (flags[7] && flags[15:8] != r_proto);
            3'd1: fail = flags[3] && ({16'h0, rdata[47:0]} != smac);
            3'd2: fail = flags[4] && ({16'h0, rdata[47:0]} != dmac);
            3'd3: fail = (flags[16] && (!r_ports || r_sport < rdata[15:0]
                                        || r_sport > rdata[31:16]))
                      || (flags[17] && (!r_ports || r_dport < rdata[47:32]
                                        || r_dport > rdata[63:48]));
            3'd4: fail = flags[5] && (flags[18] != r_fam || ((r_shi ^ rdata)
                         & mask_hi(clamp_len(flags[31:24], flags[18]))) != '0);
            3'd5: fail = flags[5] && (flags[18] != r_fam || ((r_slo ^ rdata)
                         & mask_lo(clamp_len(flags[31:24], flags[18]))) != '0);
            3'd6: fail = flags[6] && (flags[19] != r_fam || ((r_dhi ^ rdata)
                         & mask_hi(clamp_len(flags[39:32], flags[19]))) != '0);
            default: fail = flags[6] && (flags[19] != r_fam || ((r_dlo ^ rdata)
                         & mask_lo(clamp_len(flags[39:32], flags[19]))) != '0);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.classify) begin
            r_fam   <= is_v6;
            r_proto <= proto_c;
            r_ports <= ports_c;
            r_sport <= is_v4 ? r_v4p[31:16] : {r_hdr[54], r_hdr[55]};
            r_dport <= is_v4 ? r_v4p[15:0]  : {r_hdr[56], r_hdr[57]};
            if (is_v4) begin
                r_shi <= {r_hdr[26], r_hdr[27], r_hdr[28], r_hdr[29], 32'h0};
                r_slo <= '0;
                r_dhi <= {r_hdr[30], r_hdr[31], r_hdr[32], r_hdr[33], 32'h0};
                r_dlo <= '0;
            end else begin
                r_shi <= {r_hdr[22], r_hdr[23], r_hdr[24], r_hdr[25],
                          r_hdr[26], r_hdr[27], r_hdr[28], r_hdr[29]};
                r_slo <= {r_hdr[30], r_hdr[31], r_hdr[32], r_hdr[33],
                          r_hdr[34], r_hdr[35], r_hdr[36], r_hdr[37]};
                r_dhi <= {r_hdr[38], r_hdr[39], r_hdr[40], r_hdr[41],
                          r_hdr[42], r_hdr[43], r_hdr[44], r_hdr[45]};
                r_dlo <= {r_hdr[46], r_hdr[47], r_hdr[48], r_hdr[49],
                          r_hdr[50], r_hdr[51], r_hdr[52], r_hdr[53]};
            end
            r_res  <= {4'd0, i_enable ? RSN_SHORT : RSN_OFF, 1'b1};
            r_rule <= '0;
            r_word <= '0;
        end
        if (i_cmd.eval && r_word == 3'd0) r_flags <= rdata;
        if (i_cmd.next_word) r_word <= r_word + 3'd1;
        if (i_cmd.next_rule) begin
            r_rule <= r_rule + CW'(1);
            r_word <= '0;
        end
        if (i_cmd.fin_hit) r_res <= {4'(r_rule), RSN_HIT, r_flags[0]};
        if (i_cmd.fin_def) r_res <= {4'd0, RSN_DEFAULT, i_default};
        if (i_cmd.push) r_od <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_stat.need_walk  = i_enable && (r_len >= 7'(ETH_HDR))
                               && ((is_v4 && v4_ok) || (is_v6 && v6_ok));
    assign o_stat.fail       = fail;
    assign o_stat.word_last  = (r_word == 3'd7);
    assign o_stat.rules_done = (r_rule >= ncap);
    assign o_stat.out_free   = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
endmodule

[sv/aff_chk.sv]
// Port-level checker for the ACL frame filter and its bind.
module aff_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        pready
);
    import aff_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("verdict dropped while stalled");

    a_off_allows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == RSN_OFF |-> m_axis_tdata[0])
        else $error("filter off must allow");

    a_rule_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] != RSN_HIT |-> m_axis_tdata[6:3] == 4'd0)
        else $error("rule index set without a rule hit");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_FRAME && s_axis_tlast
        |=> !s_axis_tready)
        else $error("request taken during verdict");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind acl_frame_filter aff_chk u_aff_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
